/* hw/rtl/task_liveness_watchdog_monitor_assert.svh */
// Assertion macros shared by the watchdog monitor RTL.
`ifndef TASK_LIVENESS_WATCHDOG_MONITOR_ASSERT_SVH
`define TASK_LIVENESS_WATCHDOG_MONITOR_ASSERT_SVH

// a implies b on the same edge
`define TLWM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("tlwm implication violated");

// a implies b on the next edge
`define TLWM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("tlwm next-cycle implication violated");

// expression always holds
`define TLWM_ASSERT_ALWAYS(lbl, clk, rst_n, a) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error("tlwm invariant violated");

`endif

/* hw/rtl/tlwm_pkg.sv */
// Package: sizes, opcodes, controller states and cell interface types.
package tlwm_pkg;

	localparam int TASKS      = 16;
	localparam int COUNT_BITS = 16;
	localparam int ID_W       = 8;

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_UNREGISTER = 2'd1,
		OP_FEED       = 2'd2,
		OP_CHECK      = 2'd3
	} opcode_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} ctrl_state_t;

	// command broadcast to every cell
	typedef struct packed {
		logic            reg_en;
		logic            unreg_en;
		logic            feed_en;
		logic [ID_W-1:0] id;
	} cell_cmd_t;

	// per-cell status back to the controller
	typedef struct packed {
		logic reg_hit;
		logic stall;
	} cell_stat_t;

endpackage

/* hw/rtl/task_liveness_watchdog_monitor.sv */
// Top level: command decode, walk controller, result buffering and the cell chain.
//
// Software watchdog monitor for up to TASKS tasks. Each input item carries an
// opcode (register, unregister, feed, periodic check) and a task id; each item
// returns exactly one result item with status (0 ok, 1 error) and kick.
// Input and output use valid/ready; an item moves when valid and ready are high.
// Register, unregister and feed finish in the cycle of acceptance; the result
// passes through the holding register to the output register once it is free.
// A check sends a token down the row of task cells, one cell per cycle; it ends
// early at the first stalled task, and its result takes the same path to the
// output. The block takes one item at a time.
// A finished result waits in a holding register and then the output register,
// so one further item is accepted and completed while the receiver stalls;
// after that in_ready stays low until out_ready drains the output.
// Reset clears all registered flags, feed counters and snapshots at once and
// empties both result registers.
module task_liveness_watchdog_monitor import tlwm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      opcode,
	input  logic [ID_W-1:0] task_id,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            status,
	output logic            kick
);

	`include "task_liveness_watchdog_monitor_assert.svh"

	ctrl_state_t state_q, state_d;

	cell_cmd_t         cmd;
	cell_stat_t        stat   [TASKS];
	logic [TASKS:0]    tok;
	logic [TASKS-1:0]  stall_vec;
	logic [TASKS-1:0]  hit_vec;
	logic              any_stall;
	logic              any_hit;
	logic              in_range;
	logic              accept;
	logic              start;

	logic              done_valid_q;
	logic              done_status_q;
	logic              done_kick_q;
	logic              done_set;
	logic              done_status_d;
	logic              done_kick_d;
	logic              done_move;

	logic              out_valid_q;
	logic              out_status_q;
	logic              out_kick_q;

	assign in_range = ({1'b0, task_id} < (ID_W + 1)'(TASKS));
	assign in_ready = (state_q == ST_IDLE) && !done_valid_q;
	assign accept   = in_valid && in_ready;

	assign cmd.reg_en   = accept && (opcode_t'(opcode) == OP_REGISTER);
	assign cmd.unreg_en = accept && (opcode_t'(opcode) == OP_UNREGISTER);
	assign cmd.feed_en  = accept && (opcode_t'(opcode) == OP_FEED);
	assign cmd.id       = task_id;

	assign start  = accept && (opcode_t'(opcode) == OP_CHECK);
	assign tok[0] = start;

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		tlwm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.index   (ID_W'(i)),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.stat    (stat[i])
		);
		assign stall_vec[i] = stat[i].stall;
		assign hit_vec[i]   = stat[i].reg_hit;
	end

	assign any_stall = |stall_vec;
	assign any_hit   = |hit_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		done_set      = 1'b0;
		done_status_d = 1'b0;
		done_kick_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (opcode_t'(opcode))
						OP_REGISTER: begin
							done_set      = 1'b1;
							done_status_d = !in_range || any_hit;
						end
						OP_UNREGISTER: begin
							done_set = 1'b1;
						end
						OP_FEED: begin
							done_set      = 1'b1;
							done_status_d = !in_range;
						end
						OP_CHECK: begin
							// cell 0 holds the token now; a stall there ends the walk at once
							if (any_stall) begin
								done_set      = 1'b1;
								done_status_d = 1'b1;
							end else begin
								state_d = ST_WALK;
							end
						end
						default: begin
							done_set = 1'b1;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (any_stall) begin
					done_set      = 1'b1;
					done_status_d = 1'b1;
					state_d       = ST_IDLE;
				end else if (tok[TASKS]) begin
					done_set    = 1'b1;
					done_kick_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// move the held result forward when the output register frees up
	assign done_move = done_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (done_set) begin
				done_valid_q <= 1'b1;
			end else if (done_move) begin
				done_valid_q <= 1'b0;
			end
			if (done_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_set) begin
			done_status_q <= done_status_d;
			done_kick_q   <= done_kick_d;
		end
		if (done_move) begin
			out_status_q <= done_status_q;
			out_kick_q   <= done_kick_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign kick      = out_kick_q;

	// at most one cell holds the walk token, and only during a walk
	`TLWM_ASSERT_ALWAYS(a_tok_onehot, clk, arst_n, $onehot0(tok))
	`TLWM_ASSERT_IMP(a_tok_in_walk, clk, arst_n, |tok[TASKS:1], state_q == ST_WALK)
	// a held result is never overwritten before it moves on
	`TLWM_ASSERT_IMP(a_no_overwrite, clk, arst_n, done_set, !done_valid_q)
	// a check always ends with a result
	`TLWM_ASSERT_NEXT(a_walk_result, clk, arst_n,
		(state_q == ST_WALK) && (state_d == ST_IDLE), done_valid_q)

endmodule

/* hw/rtl/tlwm_cell.sv */
// One task entry: registered flag, feed counter, snapshot and walk token stage.
module tlwm_cell import tlwm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_cmd_t       cmd,
	input  logic [ID_W-1:0] index,
	input  logic            tok_in,
	output logic            tok_out,
	output cell_stat_t      stat
);

	logic                  reg_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] snap_q;
	logic                  tok_q;
	logic                  match;
	logic                  stall;

	assign match = (cmd.id == index);
	// stalled: token here, registered and no feed since the last refresh
	assign stall = tok_in && reg_q && (cnt_q == snap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q  <= 1'b0;
			cnt_q  <= '0;
			snap_q <= '0;
			tok_q  <= 1'b0;
		end else begin
			if (cmd.reg_en && match) begin
				reg_q <= 1'b1;
			end
			if (cmd.unreg_en && match) begin
				reg_q <= 1'b0;
			end
			if (cmd.feed_en && match) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// refresh a progressing task as the token passes
			if (tok_in && reg_q && !stall) begin
				snap_q <= cnt_q;
			end
			// hand the token on unless the walk stops here
			tok_q <= tok_in && !stall;
		end
	end

	assign tok_out       = tok_q;
	assign stat.reg_hit  = reg_q && match;
	assign stat.stall    = stall;

endmodule
